// ===== sv/salru_pkg.sv =====
// Shared types and constants for the set-associative LRU tracker.
`default_nettype none
package salru_pkg;
  localparam int MaxSets = 256;
  localparam int MaxWays = 8;
  localparam int SetW = $clog2(MaxSets);
  localparam int WayW = 3;
  localparam int TagW = 31;
  localparam int AgeW = 3;
  localparam logic [AgeW-1:0] AgeMax = 3'd7;
  localparam logic [1:0] RegOffset = 2'd0;
  localparam logic [1:0] RegIndex = 2'd1;
  localparam logic [1:0] RegWays = 2'd2;

  typedef struct packed {
    logic [SetW-1:0] set;
    logic [TagW-1:0] tag;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [WayW-1:0]  way;
    logic             evicted;
    logic [TagW-1:0]  evicted_tag;
    logic [31:0]      access_total;
    logic [31:0]      hit_total;
    logic [31:0]      miss_total;
  } res_t;
endpackage
`default_nettype wire

// ===== sv/set_assoc_cache_lru_tracker.sv =====
// Top level: tag-only set-associative cache tracker with true LRU.
// Flow: queue hand-off with set read, decide, write-back into the result
// register; write-back waits while an unpopped result is held.
// One request is worked on at a time, as the read/write-back sequence runs
// on the shared tag, valid and age memories.
// Reset: synchronous; a clearing pass of valid bits and ages over every set
// follows, during which requests queue but are not processed.
`default_nettype none
module set_assoc_cache_lru_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] address,
  input  wire logic        push,
  output logic             full,
  output logic             hit,
  output logic [2:0]       way,
  output logic             evicted,
  output logic [30:0]      evicted_tag,
  output logic [31:0]      access_total,
  output logic [31:0]      hit_total,
  output logic [31:0]      miss_total,
  output logic             empty,
  input  wire logic        pop,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  logic [3:0] block_offset_bits, set_index_bits, ways_in_use;
  salru_pkg::req_t req;
  salru_pkg::res_t res;
  logic req_valid, req_take, clearing;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset_bits <= 4'd4;
      set_index_bits <= 4'd0;
      ways_in_use <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        salru_pkg::RegOffset: block_offset_bits <= cfg_data;
        salru_pkg::RegIndex:  set_index_bits <= cfg_data;
        salru_pkg::RegWays:   ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  salru_front u_front (.clk, .rst, .address, .push, .full, .block_offset_bits,
    .set_index_bits, .req, .req_valid, .req_take);
  salru_back u_back (.clk, .rst, .req, .req_valid, .req_take, .ways_in_use,
    .res, .empty, .pop, .clearing);

  assign hit = res.hit;
  assign way = res.way;
  assign evicted = res.evicted;
  assign evicted_tag = res.evicted_tag;
  assign access_total = res.access_total;
  assign hit_total = res.hit_total;
  assign miss_total = res.miss_total;

  a_noclear_take: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req_take) else $error("request taken during clear");
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (!empty && evicted) |-> !hit) else $error("eviction on hit");
  a_total: assert property (@(posedge clk) disable iff (rst)
    (!empty && !(&access_total)) |-> (access_total == hit_total + miss_total))
    else $error("totals disagree");
endmodule
`default_nettype wire

// ===== sv/salru_front.sv =====
// Front end: accept address, split into set and tag, queue the request.
`default_nettype none
module salru_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          address,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [3:0]           block_offset_bits,
  input  wire logic [3:0]           set_index_bits,
  output salru_pkg::req_t           req,
  output logic                      req_valid,
  input  wire logic                 req_take
);
  localparam logic [3:0] MaxIb = 4'(salru_pkg::SetW);
  salru_pkg::req_t q [2];
  logic [1:0] count;
  logic rd_ptr, wr_ptr;
  logic [3:0] off, ib;
  salru_pkg::req_t r;
  logic [31:0] sh;
  logic do_push, do_pop;

  always_comb begin
    off = block_offset_bits;
    if (off < 4'd1) off = 4'd1;
    if (off > 4'd12) off = 4'd12;
    ib = (set_index_bits > MaxIb) ? MaxIb : set_index_bits;
    sh = address >> off;
    r.set = salru_pkg::SetW'(sh & ((32'd1 << ib) - 32'd1));
    r.tag = salru_pkg::TagW'(sh >> ib);
  end

  assign full = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= r;
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ===== sv/salru_back.sv =====
// Back end: read set, decide hit/fill/evict, write back, hold result.
`default_nettype none
module salru_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire salru_pkg::req_t      req,
  input  wire logic                 req_valid,
  output logic                      req_take,
  input  wire logic [3:0]           ways_in_use,
  output salru_pkg::res_t           res,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      clearing
);
  localparam int W = salru_pkg::MaxWays;
  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;
  state_t state;

  logic [salru_pkg::TagW-1:0] tag_mem [salru_pkg::MaxSets][W];
  logic [W-1:0]               vld_mem [salru_pkg::MaxSets];
  logic [W*salru_pkg::AgeW-1:0] age_mem [salru_pkg::MaxSets];

  logic [salru_pkg::TagW-1:0] rd_tag [W];
  logic [W-1:0]               rd_vld;
  logic [W*salru_pkg::AgeW-1:0] rd_age;
  logic [salru_pkg::SetW-1:0] cset, clr;
  logic [salru_pkg::TagW-1:0] ctag;
  logic [31:0] acc, hits, miss;
  logic        res_full;
  logic        fire;

  logic [3:0] nways;
  logic [W-1:0] inuse;
  logic hit, found;
  logic [2:0] w, hw, iw, vw;
  logic [W-1:0] vld_next;
  logic [W*salru_pkg::AgeW-1:0] age_next;
  logic [salru_pkg::AgeW-1:0] a, thr;

  function automatic logic [salru_pkg::AgeW-1:0] age_of(
      input logic [W*salru_pkg::AgeW-1:0] v, input int i);
    return v[i*salru_pkg::AgeW +: salru_pkg::AgeW];
  endfunction

  always_comb begin
    nways = ways_in_use;
    if (nways < 4'd1) nways = 4'd1;
    if (nways > 4'(W)) nways = 4'(W);
    for (int i = 0; i < W; i++) inuse[i] = (4'(i) < nways);
    hit = 1'b0; hw = '0;
    for (int i = W-1; i >= 0; i--)
      if (inuse[i] && rd_vld[i] && rd_tag[i] == ctag) begin hit = 1'b1; hw = 3'(i); end
    found = 1'b0; iw = '0;
    for (int i = W-1; i >= 0; i--)
      if (inuse[i] && !rd_vld[i]) begin found = 1'b1; iw = 3'(i); end
    vw = '0;
    for (int i = 1; i < W; i++)
      if (inuse[i] && age_of(rd_age, i) > age_of(rd_age, int'(vw))) vw = 3'(i);
    w = hit ? hw : (found ? iw : vw);
    thr = age_of(rd_age, int'(w));
    age_next = rd_age;
    vld_next = rd_vld;
    vld_next[w] = 1'b1;
    for (int i = 0; i < W; i++) begin
      a = age_of(rd_age, i);
      if (3'(i) != w && inuse[i] && rd_vld[i] && a < salru_pkg::AgeMax &&
          (a < thr || (!hit && found)))
        age_next[i*salru_pkg::AgeW +: salru_pkg::AgeW] = a + 3'd1;
    end
    age_next[int'(w)*salru_pkg::AgeW +: salru_pkg::AgeW] = '0;
  end

  assign req_take = (state == S_IDLE) && req_valid;
  assign empty = !res_full;
  assign clearing = (state == S_CLEAR);
  assign fire = (state == S_WRITE) && (!res_full || pop);

  always_ff @(posedge clk) begin
    // hold the set read for the request being worked on
    if (req_take) begin
      rd_vld <= vld_mem[req.set];
      rd_age <= age_mem[req.set];
      for (int i = 0; i < W; i++) rd_tag[i] <= tag_mem[req.set][i];
    end
    if (state == S_CLEAR) begin
      vld_mem[clr] <= '0;
      age_mem[clr] <= '0;
    end else if (state == S_WRITE) begin
      vld_mem[cset] <= vld_next;
      age_mem[cset] <= age_next;
      if (!hit) tag_mem[cset][w] <= ctag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      acc <= '0; hits <= '0; miss <= '0;
      res_full <= 1'b0;
    end else begin
      if (fire) res_full <= 1'b1;
      else if (pop && res_full) res_full <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) state <= S_IDLE;
        end
        S_IDLE: if (req_valid) begin
          cset <= req.set;
          ctag <= req.tag;
          state <= S_READ;
        end
        S_READ: state <= S_WRITE;
        S_WRITE: if (fire) begin
          acc <= (&acc) ? acc : acc + 32'd1;
          if (hit) hits <= (&hits) ? hits : hits + 32'd1;
          else miss <= (&miss) ? miss : miss + 32'd1;
          res.hit <= hit;
          res.way <= w;
          res.evicted <= !hit && !found;
          res.evicted_tag <= (!hit && !found) ? rd_tag[vw] : '0;
          res.access_total <= (&acc) ? acc : acc + 32'd1;
          res.hit_total <= (hit && !(&hits)) ? hits + 32'd1 : hits;
          res.miss_total <= (!hit && !(&miss)) ? miss + 32'd1 : miss;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
